// ----- sv/hq_pkg.sv -----
// hq_pkg: shared types, codes and default sizes of the heap timer queue.
// No dependencies; imported by hq_cmp and heap_timer_queue.
package hq_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int KEY_SPACE_DEF = 1024;
  localparam int TIME_BITS_DEF = 32;

  localparam int KEY_W = 10;
  localparam int AMT_W = 24;

  typedef enum logic [2:0] {
    OP_ADVANCE = 3'd0,
    OP_ADD     = 3'd1,
    OP_FIRE    = 3'd2,
    OP_DROP    = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_QUERY   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_NEXT    = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [KEY_W-1:0] timer_key;
    logic [AMT_W-1:0] amount_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] expired_key;
    logic [AMT_W-1:0] remaining_ms;
    logic             last;
  } res_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_POS1, ST_DROP1, ST_RM0, ST_RM1,
    ST_SD0, ST_SD1, ST_SD2, ST_SD3, ST_SDE, ST_SU0, ST_SU1, ST_PLACE,
    ST_EXP_RD, ST_EXP_CHK, ST_CLR0, ST_CLR1, ST_FIN, ST_RPT, ST_RPT1
  } state_e;

endpackage

// ----- sv/hq_cmp.sv -----
// hq_cmp: shared wrap-safe time comparator (one subtractor).
// Depends on hq_pkg for the default time width.
module hq_cmp #(
  parameter int TIME_BITS = hq_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] a_i,
  input  logic [TIME_BITS-1:0] b_i,
  output logic [TIME_BITS-1:0] diff_o,
  output logic                 before_o,
  output logic                 due_o
);
  import hq_pkg::*;

  assign diff_o   = a_i - b_i;
  assign before_o = diff_o[TIME_BITS-1];
  assign due_o    = diff_o[TIME_BITS-1] || (diff_o == '0);
endmodule

// ----- sv/heap_timer_queue.sv -----
// heap_timer_queue: min-heap timer queue. Add, fire and drop place or remove one
// entry, sifting down (ST_SD0..ST_SD3) and up (ST_SU0, ST_SU1); clear
// walks every held timer; output stalls delay fire, a full add and each expiry.
// Throughput: one request in flight; the next is taken after the current one ends.
// Reset: clears count and clock, then writes every position-table entry invalid
// before the first request is accepted.
module heap_timer_queue #(
  parameter int CAPACITY  = hq_pkg::CAPACITY_DEF,
  parameter int KEY_SPACE = hq_pkg::KEY_SPACE_DEF,
  parameter int TIME_BITS = hq_pkg::TIME_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hq_pkg::req_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hq_pkg::res_t  out_res_o
);
  import hq_pkg::*;

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CIW = IW + 2;
  localparam int KW  = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [TIME_BITS-1:0] exp;
  } ent_t;

  typedef struct packed {
    logic          valid;
    logic [IW-1:0] idx;
  } pos_t;

  // storage: heap slots and per-key position table, each one read port
  ent_t heap_mem [CAPACITY];
  pos_t pos_mem  [KEY_SPACE];

  state_e state_q, state_d;
  logic [2:0]           op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [AMT_W-1:0]     amt_q, amt_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [CIW-1:0]       chi_q, chi_d;
  ent_t                 ch_q, ch_d, cur_q, cur_d;
  logic [KEY_W-1:0]     vic_q, vic_d;
  logic                 moved_q, moved_d;
  res_t                 pend_q, pend_d;
  logic                 pend_vld_q, pend_vld_d;
  res_t                 out_q, out_d;
  logic                 out_vld_q, out_vld_d;
  logic [KW-1:0]        swp_q, swp_d;

  // memory ports
  logic          hrd_en, hwr_en, prd_en, pwr_en;
  logic [IW-1:0] hrd_addr, hwr_addr;
  ent_t          hwr_data, hrd_q;
  logic [KW-1:0] prd_addr, pwr_addr;
  pos_t          pwr_data, prd_q;

  // shared comparator operands
  logic [TIME_BITS-1:0] cmp_a, cmp_b, cmp_diff;
  logic                 cmp_before, cmp_due;

  hq_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .diff_o   (cmp_diff),
    .before_o (cmp_before),
    .due_o    (cmp_due)
  );

  logic           in_acc, out_free, key_ok;
  logic [CIW-1:0] child, cnt_x;
  logic [IW-1:0]  parent, lastpos;
  state_e         ret_st;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign key_ok      = ({22'd0, in_req_i.timer_key} < 32'(KEY_SPACE));
  assign child       = CIW'({idx_q, 1'b1});
  assign cnt_x       = CIW'(cnt_q);
  assign parent      = IW'((idx_q - 1'b1) >> 1);
  assign lastpos     = IW'(cnt_q - 1'b1);
  // removals during expiry loop back to check the new root
  assign ret_st      = (op_q == OP_ADVANCE || op_q == OP_QUERY) ? ST_EXP_RD : ST_FIN;

  always_comb begin
    unique case (state_q)
      ST_SD2:  begin cmp_a = hrd_q.exp; cmp_b = ch_q.exp;  end
      ST_SD3:  begin cmp_a = ch_q.exp;  cmp_b = cur_q.exp; end
      ST_SU1:  begin cmp_a = cur_q.exp; cmp_b = hrd_q.exp; end
      default: begin cmp_a = hrd_q.exp; cmp_b = now_q;     end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:  if (swp_q == KW'(KEY_SPACE - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          priority case (in_req_i.operation)
            OP_ADVANCE, OP_QUERY: state_d = ST_EXP_RD;
            OP_ADD, OP_FIRE:      state_d = key_ok ? ST_POS1 : ST_FIN;
            OP_DROP:              state_d = (cnt_q != '0) ? ST_DROP1 : ST_FIN;
            OP_CLEAR:             state_d = ST_CLR0;
            default:              state_d = ST_FIN;
          endcase
        end
      end
      ST_POS1: begin
        if (op_q == OP_ADD) begin
          if (prd_q.valid)                 state_d = ST_SD0;
          else if (cnt_q >= CW'(CAPACITY)) state_d = out_free ? ST_FIN : ST_POS1;
          else                             state_d = ST_SU0;
        end else begin
          if (!prd_q.valid)  state_d = ST_FIN;
          else if (out_free) state_d = ST_RM0;
        end
      end
      ST_DROP1:   state_d = ST_RM0;
      ST_RM0:     state_d = (idx_q == lastpos) ? ret_st : ST_RM1;
      ST_RM1:     state_d = ST_SD0;
      ST_SD0:     state_d = (child >= cnt_x) ? ST_SDE : ST_SD1;
      ST_SD1:     state_d = (child + 1'b1 < cnt_x) ? ST_SD2 : ST_SD3;
      ST_SD2:     state_d = ST_SD3;
      ST_SD3:     state_d = cmp_before ? ST_SD0 : ST_SDE;
      ST_SDE:     state_d = moved_q ? ST_PLACE : ST_SU0;
      ST_SU0:     state_d = (idx_q == '0) ? ST_PLACE : ST_SU1;
      ST_SU1:     state_d = cmp_before ? ST_SU0 : ST_PLACE;
      ST_PLACE:   state_d = ret_st;
      ST_EXP_RD:  state_d = (cnt_q == '0) ? ST_FIN : ST_EXP_CHK;
      ST_EXP_CHK: begin
        if (!cmp_due)                     state_d = ST_FIN;
        else if (!pend_vld_q || out_free) state_d = ST_RM0;
      end
      ST_CLR0:    state_d = (CIW'(chi_q) < cnt_x) ? ST_CLR1 : ST_FIN;
      ST_CLR1:    state_d = ST_CLR0;
      ST_FIN: begin
        if (!pend_vld_q) state_d = (op_q == OP_QUERY) ? ST_RPT : ST_IDLE;
      end
      ST_RPT: begin
        if (cnt_q != '0) state_d = ST_RPT1;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_RPT1:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d = op_q; key_d = key_q; amt_d = amt_q; now_d = now_q; cnt_d = cnt_q;
    idx_d = idx_q; chi_d = chi_q; ch_d = ch_q; cur_d = cur_q; vic_d = vic_q;
    moved_d = moved_q; pend_d = pend_q; pend_vld_d = pend_vld_q; swp_d = swp_q;
    out_d = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    hrd_en = 1'b0; hrd_addr = '0; hwr_en = 1'b0; hwr_addr = idx_q; hwr_data = cur_q;
    prd_en = 1'b0; prd_addr = '0; pwr_en = 1'b0; pwr_addr = '0; pwr_data = '0;

    unique case (state_q)
      ST_INIT: begin
        pwr_en = 1'b1; pwr_addr = swp_q; pwr_data = '0;
        swp_d  = swp_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d  = in_req_i.operation;
          key_d = in_req_i.timer_key;
          amt_d = in_req_i.amount_ms;
          if (in_req_i.operation == OP_ADVANCE || in_req_i.operation == OP_QUERY)
            now_d = now_q + TIME_BITS'(in_req_i.amount_ms);
          prd_en   = 1'b1;
          prd_addr = KW'(in_req_i.timer_key);
          hrd_en   = 1'b1;
          chi_d    = '0;
        end
      end
      ST_POS1: begin
        cur_d   = '{key: key_q, exp: now_q + TIME_BITS'(amt_q)};
        moved_d = 1'b0;
        if (op_q == OP_ADD) begin
          if (prd_q.valid) begin
            idx_d = prd_q.idx;
          end else if (cnt_q >= CW'(CAPACITY)) begin
            if (out_free) begin
              out_d = '{kind: KIND_FULL, expired_key: key_q, remaining_ms: '0, last: 1'b1};
              out_vld_d = 1'b1;
            end
          end else begin
            idx_d = IW'(cnt_q);
            cnt_d = cnt_q + 1'b1;
          end
        end else if (prd_q.valid && out_free) begin
          out_d = '{kind: KIND_EXPIRED, expired_key: key_q, remaining_ms: '0, last: 1'b1};
          out_vld_d = 1'b1;
          vic_d = key_q;
          idx_d = prd_q.idx;
        end
      end
      ST_DROP1: begin
        vic_d = hrd_q.key;
        idx_d = '0;
      end
      ST_RM0: begin
        pwr_en = 1'b1; pwr_addr = KW'(vic_q); pwr_data = '0;
        cnt_d  = cnt_q - 1'b1;
        hrd_en = 1'b1; hrd_addr = lastpos;
      end
      ST_RM1: begin
        cur_d   = hrd_q;
        moved_d = 1'b0;
      end
      ST_SD0: begin
        hrd_en = 1'b1; hrd_addr = IW'(child);
      end
      ST_SD1: begin
        ch_d   = hrd_q;
        chi_d  = child;
        hrd_en = 1'b1; hrd_addr = IW'(child + 1'b1);
      end
      ST_SD2: begin
        if (cmp_before) begin
          ch_d  = hrd_q;
          chi_d = chi_q + 1'b1;
        end
      end
      ST_SD3: begin
        if (cmp_before) begin
          hwr_en = 1'b1; hwr_data = ch_q;
          pwr_en = 1'b1; pwr_addr = KW'(ch_q.key); pwr_data = '{valid: 1'b1, idx: idx_q};
          idx_d  = IW'(chi_q);
          moved_d = 1'b1;
        end
      end
      ST_SU0: begin
        hrd_en = 1'b1; hrd_addr = parent;
      end
      ST_SU1: begin
        if (cmp_before) begin
          hwr_en = 1'b1; hwr_data = hrd_q;
          pwr_en = 1'b1; pwr_addr = KW'(hrd_q.key); pwr_data = '{valid: 1'b1, idx: idx_q};
          idx_d  = parent;
        end
      end
      ST_PLACE: begin
        hwr_en = 1'b1; hwr_data = cur_q;
        pwr_en = 1'b1; pwr_addr = KW'(cur_q.key); pwr_data = '{valid: 1'b1, idx: idx_q};
      end
      ST_EXP_RD: begin
        hrd_en = 1'b1; hrd_addr = '0;
      end
      ST_EXP_CHK: begin
        // hold each expiry back one step so the final one can carry last
        if (cmp_due && (!pend_vld_q || out_free)) begin
          if (pend_vld_q) begin
            out_d = pend_q; out_d.last = 1'b0;
            out_vld_d = 1'b1;
          end
          pend_d = '{kind: KIND_EXPIRED, expired_key: hrd_q.key, remaining_ms: '0, last: 1'b0};
          pend_vld_d = 1'b1;
          vic_d = hrd_q.key;
          idx_d = '0;
        end
      end
      ST_CLR0: begin
        hrd_en = 1'b1; hrd_addr = IW'(chi_q);
        if (!(chi_q < cnt_x)) cnt_d = '0;
      end
      ST_CLR1: begin
        pwr_en = 1'b1; pwr_addr = KW'(hrd_q.key); pwr_data = '0;
        chi_d  = chi_q + 1'b1;
      end
      ST_FIN: begin
        if (pend_vld_q && out_free) begin
          out_d = pend_q; out_d.last = (op_q != OP_QUERY);
          out_vld_d = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      ST_RPT: begin
        hrd_en = 1'b1; hrd_addr = '0;
        if (cnt_q == '0 && out_free) begin
          out_d = '{kind: KIND_EMPTY, expired_key: '0, remaining_ms: '0, last: 1'b1};
          out_vld_d = 1'b1;
        end
      end
      ST_RPT1: begin
        if (out_free) begin
          out_d = '{kind: KIND_NEXT, expired_key: hrd_q.key,
                    remaining_ms: cmp_diff[AMT_W-1:0], last: 1'b1};
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      cnt_q      <= '0;
      now_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      swp_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      now_q      <= now_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      swp_q      <= swp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    amt_q   <= amt_d;
    idx_q   <= idx_d;
    chi_q   <= chi_d;
    ch_q    <= ch_d;
    cur_q   <= cur_d;
    vic_q   <= vic_d;
    moved_q <= moved_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (hwr_en) heap_mem[hwr_addr] <= hwr_data;
    if (hrd_en) hrd_q <= heap_mem[hrd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pwr_en) pos_mem[pwr_addr] <= pwr_data;
    if (prd_en) prd_q <= pos_mem[prd_addr];
  end

endmodule
